FILE: sv/svae_pkg.sv
// ----------------------------------------------------------------------------
// svae_pkg
// Shared types, codes, widths and table functions of the sine voice with
// attack/decay envelope.
// ----------------------------------------------------------------------------
package svae_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int EXP_TABLE_DEPTH_DEF  = 256;
    localparam int REFERENCE_KEY_DEF    = 57;

    localparam int BASE_W     = 31;
    localparam int SPO_W      = 8;
    localparam int ENV_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int SINE_W     = 11;
    localparam int EXP_W      = 32;
    localparam int PHASE_W    = 32;
    localparam int KEY_W      = 7;
    localparam int SAMPLE_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INCREMENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_OCTAVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_ENABLE   = 3'd4;

    localparam logic [BASE_W-1:0] BASE_INCREMENT_RST   = 31'd39370534;
    localparam logic [SPO_W-1:0]  STEPS_PER_OCTAVE_RST = 8'd12;
    localparam logic [ENV_W-1:0]  ATTACK_STEP_RST      = 24'd17476;
    localparam logic [ENV_W-1:0]  DECAY_STEP_RST       = 24'd17476;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_ON    = 2'd1;
    localparam logic [1:0] REQ_OFF   = 2'd2;
    localparam logic [1:0] REQ_CHOKE = 2'd3;

    localparam logic [ENV_W-1:0]   UNITY_GAIN = 24'd8388608;
    localparam logic [PHASE_W-1:0] HALF_RATE  = 32'h8000_0000;

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam longint unsigned SINE_PEAK   = 64'd1638;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ATTACK,
        MODE_PLAYING,
        MODE_DECAY
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXP_RD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SHIFT,
        ST_TICK_RD,
        ST_TICK_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic div_step;
        logic exp_rd;
        logic mul_lo;
        logic mul_hi;
        logic step_calc;
        logic tick_rd;
        logic tick_mul;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    // Division by the Taylor term index, one literal divisor per arm.
    function automatic longint unsigned exp_div(input longint unsigned v, input int n);
        longint unsigned r;
        case (n)
            2:  r = v / 2;
            3:  r = v / 3;
            4:  r = v / 4;
            5:  r = v / 5;
            6:  r = v / 6;
            7:  r = v / 7;
            8:  r = v / 8;
            9:  r = v / 9;
            10: r = v / 10;
            11: r = v / 11;
            12: r = v / 12;
            13: r = v / 13;
            14: r = v / 14;
            15: r = v / 15;
            16: r = v / 16;
            default: r = v;
        endcase
        return r;
    endfunction

    // Division by (2n)(2n+1) for the sine series.
    function automatic longint unsigned sine_div(input longint unsigned v, input int n);
        longint unsigned r;
        case (n)
            1:  r = v / 6;
            2:  r = v / 20;
            3:  r = v / 42;
            4:  r = v / 72;
            5:  r = v / 110;
            6:  r = v / 156;
            7:  r = v / 210;
            8:  r = v / 272;
            9:  r = v / 342;
            10: r = v / 420;
            default: r = v / 506;
        endcase
        return r;
    endfunction

    // 2^(idx / 2^aw) in Q2.30.
    function automatic logic [EXP_W-1:0] exp2_entry(input int idx, input int aw);
        longint unsigned y;
        longint unsigned term;
        longint unsigned sum;
        y    = (64'(idx) * LN2_Q30) >> aw;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= 16; n++)
        begin
            term = exp_div((term * y) >> 30, n);
            sum  = sum + term;
        end
        return sum[EXP_W-1:0];
    endfunction

    // Quarter-wave sine entry at 0.05 of full scale, k in 0..2^aw.
    function automatic logic [SINE_W-1:0] sine_entry(input int k, input int aw);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          s;
        longint unsigned r;
        x    = (64'(k) * HALF_PI_Q30) >> aw;
        x2   = (x * x) >> 30;
        term = x;
        s    = $signed(x);
        for (int n = 1; n <= 11; n++)
        begin
            term = sine_div((term * x2) >> 30, n);
            if ((n & 1) != 0)
                s = s - $signed(term);
            else
                s = s + $signed(term);
        end
        if (s < 0)
            s = 0;
        if (s > $signed(ONE_Q30))
            s = $signed(ONE_Q30);
        r = ($unsigned(s) * SINE_PEAK + (ONE_Q30 >> 1)) >> 30;
        return r[SINE_W-1:0];
    endfunction

endpackage

FILE: sv/svae_ctrl.sv
// ----------------------------------------------------------------------------
// svae_ctrl
// Sequencer of the voice: steps the datapath through note-on pitch setup,
// tick sample generation and event handling, and owns the output beat flag.
// ----------------------------------------------------------------------------
module svae_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           req_type,
    input  logic                 out_stall,
    input  svae_pkg::dp_status_t status,
    output svae_pkg::dp_cmd_t    cmd,
    output logic                 in_stall,
    output logic                 out_valid
);

    svae_pkg::state_t state_reg;
    svae_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svae_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        svae_pkg::REQ_ON:    state_next = svae_pkg::ST_DIV;
                        svae_pkg::REQ_TICK:  state_next = svae_pkg::ST_TICK_RD;
                        svae_pkg::REQ_OFF:   state_next = svae_pkg::ST_DONE;
                        svae_pkg::REQ_CHOKE: state_next = svae_pkg::ST_DONE;
                    endcase
                end
            end
            svae_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = svae_pkg::ST_EXP_RD;
            end
            svae_pkg::ST_EXP_RD:   state_next = svae_pkg::ST_MUL_LO;
            svae_pkg::ST_MUL_LO:   state_next = svae_pkg::ST_MUL_HI;
            svae_pkg::ST_MUL_HI:   state_next = svae_pkg::ST_SHIFT;
            svae_pkg::ST_SHIFT:    state_next = svae_pkg::ST_DONE;
            svae_pkg::ST_TICK_RD:  state_next = svae_pkg::ST_TICK_MUL;
            svae_pkg::ST_TICK_MUL: state_next = svae_pkg::ST_DONE;
            svae_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = svae_pkg::ST_IDLE;
            end
            default: state_next = svae_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.latch     = (state_reg == svae_pkg::ST_IDLE) && in_valid;
        cmd.div_step  = (state_reg == svae_pkg::ST_DIV) && !status.div_done;
        cmd.exp_rd    = (state_reg == svae_pkg::ST_EXP_RD);
        cmd.mul_lo    = (state_reg == svae_pkg::ST_MUL_LO);
        cmd.mul_hi    = (state_reg == svae_pkg::ST_MUL_HI);
        cmd.step_calc = (state_reg == svae_pkg::ST_SHIFT);
        cmd.tick_rd   = (state_reg == svae_pkg::ST_TICK_RD);
        cmd.tick_mul  = (state_reg == svae_pkg::ST_TICK_MUL);
        cmd.finish    = (state_reg == svae_pkg::ST_DONE) && slot_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svae_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != svae_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: sv/svae_dp.sv
// ----------------------------------------------------------------------------
// svae_dp
// Datapath of the voice: configuration registers, voice state, the
// restoring divider and exp2 table for the pitch, the shared partial-product
// multiplier, the quarter-wave table and the gain multiplier.
// ----------------------------------------------------------------------------
module svae_dp #(
    parameter int SINE_TABLE_DEPTH = svae_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int EXP_TABLE_DEPTH  = svae_pkg::EXP_TABLE_DEPTH_DEF,
    parameter int REFERENCE_KEY    = svae_pkg::REFERENCE_KEY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  svae_pkg::dp_cmd_t                   cmd,
    output svae_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [svae_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [svae_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          req_type,
    input  logic signed [15:0]                  note_ident,
    input  logic signed [15:0]                  chan,
    input  logic signed [7:0]                   key_number,
    output logic signed [svae_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                matched,
    output logic                                busy_res,
    output logic                                just_ended
);

    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int EXP_AW  = $clog2(EXP_TABLE_DEPTH);
    localparam int NUM_W   = svae_pkg::KEY_W + EXP_AW;
    localparam int Q_W     = NUM_W + 1;
    localparam int OCT_W   = Q_W - EXP_AW;
    localparam int SH_W    = OCT_W + 2;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int K_W     = SINE_AW + 1;
    localparam int PP_W    = svae_pkg::BASE_W + 16;
    localparam int TM_W    = svae_pkg::SINE_W + svae_pkg::ENV_W;

    // Constant tables, read through registered outputs.
    logic [svae_pkg::EXP_W-1:0]  exp_rom  [EXP_TABLE_DEPTH];
    logic [svae_pkg::SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_exp
        localparam logic [svae_pkg::EXP_W-1:0] EXP_VAL = svae_pkg::exp2_entry(g, EXP_AW);
        assign exp_rom[g] = EXP_VAL;
    end

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_sine
        localparam logic [svae_pkg::SINE_W-1:0] SINE_VAL = svae_pkg::sine_entry(g, SINE_AW);
        assign sine_rom[g] = SINE_VAL;
    end

    // Configuration.
    logic [svae_pkg::BASE_W-1:0] base_reg;
    logic [svae_pkg::SPO_W-1:0]  spo_reg;
    logic [svae_pkg::ENV_W-1:0]  attack_reg;
    logic [svae_pkg::ENV_W-1:0]  decay_reg;
    logic                        sustain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= svae_pkg::BASE_INCREMENT_RST;
            spo_reg     <= svae_pkg::STEPS_PER_OCTAVE_RST;
            attack_reg  <= svae_pkg::ATTACK_STEP_RST;
            decay_reg   <= svae_pkg::DECAY_STEP_RST;
            sustain_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svae_pkg::CFG_BASE_INCREMENT:   base_reg    <= cfg_data;
                svae_pkg::CFG_STEPS_PER_OCTAVE: spo_reg     <= cfg_data[svae_pkg::SPO_W-1:0];
                svae_pkg::CFG_ATTACK_STEP:      attack_reg  <= cfg_data[svae_pkg::ENV_W-1:0];
                svae_pkg::CFG_DECAY_STEP:       decay_reg   <= cfg_data[svae_pkg::ENV_W-1:0];
                svae_pkg::CFG_SUSTAIN_ENABLE:   sustain_reg <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    // Latched request.
    logic [1:0]  req_reg;
    logic [15:0] nid_reg;
    logic [15:0] ch_reg;
    logic [7:0]  key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            nid_reg <= note_ident;
            ch_reg  <= chan;
            key_reg <= key_number;
        end
    end

    // Restoring divider: |key - reference| * table depth over steps per octave.
    logic [NUM_W-1:0]          num_reg;
    logic [NUM_W-1:0]          quo_reg;
    logic [svae_pkg::SPO_W-1:0] rem_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [8:0]         key_diff;
    logic [8:0]                diff_mag;
    logic [svae_pkg::SPO_W-1:0] tet;
    logic [svae_pkg::SPO_W:0]  trial;
    logic                      trial_ge;

    assign key_diff = $signed({2'b00, key_number[6:0]}) - $signed(9'(REFERENCE_KEY));
    assign diff_mag = key_diff[8] ? 9'(-key_diff) : 9'(key_diff);
    assign tet      = (spo_reg == '0) ? svae_pkg::SPO_W'(1) : spo_reg;
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, tet});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.latch)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            num_reg <= {diff_mag[svae_pkg::KEY_W-1:0], {EXP_AW{1'b0}}};
            neg_reg <= key_diff[8];
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? svae_pkg::SPO_W'(trial - {1'b0, tet})
                                : trial[svae_pkg::SPO_W-1:0];
        end
    end

    assign status.div_done = (cnt_reg == CNT_W'(NUM_W));

    // Floor quotient, octave and table index.
    logic [Q_W-1:0]   q_mag;
    logic [Q_W-1:0]   q_val;
    logic [OCT_W-1:0] oct_reg;
    logic [svae_pkg::EXP_W-1:0] exp_q_reg;

    assign q_mag = {1'b0, quo_reg} + Q_W'(rem_reg != '0);
    assign q_val = neg_reg ? Q_W'(-q_mag) : {1'b0, quo_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.exp_rd)
        begin
            exp_q_reg <= exp_rom[q_val[EXP_AW-1:0]];
            oct_reg   <= q_val[Q_W-1:EXP_AW];
        end
    end

    // base * exp2 entry in two 31 x 16 partial products.
    logic [15:0]   mul_b;
    logic [PP_W-1:0] pp;
    logic [63:0]   prod_reg;

    assign mul_b = cmd.mul_hi ? exp_q_reg[31:16] : exp_q_reg[15:0];
    assign pp    = base_reg * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
            prod_reg <= 64'(pp);
        else if (cmd.mul_hi)
            prod_reg <= prod_reg + {1'b0, pp, 16'b0};
    end

    // Octave shift with saturation at half the sample rate.
    logic signed [SH_W-1:0] sh;
    logic [SH_W-1:0]        nsh;
    logic [63:0]            shifted;
    logic [svae_pkg::PHASE_W-1:0] step_val;
    logic [svae_pkg::PHASE_W-1:0] step_calc_reg;

    assign sh  = $signed({{(SH_W-OCT_W){oct_reg[OCT_W-1]}}, oct_reg}) - $signed(SH_W'(30));
    assign nsh = SH_W'(-sh);

    always_comb
    begin
        shifted  = '0;
        step_val = '0;
        if (sh <= 0)
        begin
            if (nsh < SH_W'(64))
            begin
                shifted  = prod_reg >> nsh[5:0];
                step_val = (shifted > 64'(svae_pkg::HALF_RATE)) ? svae_pkg::HALF_RATE
                                                                : shifted[31:0];
            end
        end
        else if (prod_reg != '0)
        begin
            if ((sh >= $signed(SH_W'(32))) ||
                (prod_reg > (64'(svae_pkg::HALF_RATE) >> sh[4:0])))
                step_val = svae_pkg::HALF_RATE;
            else
            begin
                shifted  = prod_reg << sh[4:0];
                step_val = shifted[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_calc)
            step_calc_reg <= step_val;
    end

    // Voice state.
    svae_pkg::mode_t mode_reg, mode_next;
    logic [15:0]     held_note_reg, held_note_next;
    logic [15:0]     held_chan_reg, held_chan_next;
    logic [svae_pkg::KEY_W-1:0] held_key_reg, held_key_next;
    logic [svae_pkg::PHASE_W-1:0] phase_acc_reg, phase_acc_next;
    logic [svae_pkg::PHASE_W-1:0] phase_step_reg, phase_step_next;
    logic [svae_pkg::ENV_W-1:0]   gain_reg, gain_next;

    // Tick: table read, then gain multiply.
    logic [SINE_AW+1:0]          ph_idx;
    logic [K_W-1:0]              rom_k;
    logic [svae_pkg::SINE_W-1:0] sine_q_reg;
    logic [1:0]                  quad_reg;
    logic [TM_W-1:0]             tmul_reg;

    assign ph_idx = phase_acc_reg[svae_pkg::PHASE_W-1 -: SINE_AW+2];
    assign rom_k  = ph_idx[SINE_AW] ? K_W'(SINE_TABLE_DEPTH) - {1'b0, ph_idx[SINE_AW-1:0]}
                                    : {1'b0, ph_idx[SINE_AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.tick_rd)
        begin
            sine_q_reg <= sine_rom[rom_k];
            quad_reg   <= ph_idx[SINE_AW+1:SINE_AW];
        end
        if (cmd.tick_mul)
            tmul_reg <= sine_q_reg * gain_reg;
    end

    logic [TM_W:0]                   rnd_sum;
    logic [svae_pkg::SAMPLE_W-1:0]   tick_mag;
    logic [svae_pkg::SAMPLE_W-1:0]   tick_sample;
    logic [svae_pkg::ENV_W:0]        attack_sum;
    logic                            ev_match;

    assign rnd_sum     = {1'b0, tmul_reg} + (TM_W+1)'(24'd4194304);
    assign tick_mag    = svae_pkg::SAMPLE_W'(rnd_sum[TM_W:23]);
    assign tick_sample = quad_reg[1] ? svae_pkg::SAMPLE_W'(-tick_mag) : tick_mag;
    assign attack_sum  = {1'b0, gain_reg} + {1'b0, attack_reg};
    assign ev_match    = (mode_reg != svae_pkg::MODE_IDLE) &&
                         ((key_reg == 8'hFF) || (key_reg == {1'b0, held_key_reg})) &&
                         ((nid_reg == 16'hFFFF) || (nid_reg == held_note_reg)) &&
                         ((ch_reg == 16'hFFFF) || (ch_reg == held_chan_reg));

    logic [svae_pkg::SAMPLE_W-1:0] sample_next;
    logic                          matched_next;
    logic                          ended_next;
    logic                          advance;

    always_comb
    begin
        mode_next       = mode_reg;
        held_note_next  = held_note_reg;
        held_chan_next  = held_chan_reg;
        held_key_next   = held_key_reg;
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        gain_next       = gain_reg;
        sample_next     = '0;
        matched_next    = 1'b0;
        ended_next      = 1'b0;
        advance         = 1'b0;
        unique case (req_reg)
            svae_pkg::REQ_ON:
            begin
                mode_next       = svae_pkg::MODE_ATTACK;
                held_note_next  = nid_reg;
                held_chan_next  = ch_reg;
                held_key_next   = key_reg[svae_pkg::KEY_W-1:0];
                phase_acc_next  = '0;
                gain_next       = '0;
                phase_step_next = step_calc_reg;
            end
            svae_pkg::REQ_OFF:
            begin
                if (ev_match)
                begin
                    matched_next = 1'b1;
                    if ((mode_reg == svae_pkg::MODE_ATTACK) ||
                        (mode_reg == svae_pkg::MODE_PLAYING))
                        mode_next = svae_pkg::MODE_DECAY;
                end
            end
            svae_pkg::REQ_CHOKE:
            begin
                if (ev_match)
                begin
                    matched_next = 1'b1;
                    mode_next    = svae_pkg::MODE_IDLE;
                end
            end
            svae_pkg::REQ_TICK:
            begin
                unique case (mode_reg)
                    svae_pkg::MODE_IDLE: ;
                    svae_pkg::MODE_ATTACK:
                    begin
                        sample_next = tick_sample;
                        advance     = 1'b1;
                        if (attack_sum >= {1'b0, svae_pkg::UNITY_GAIN})
                        begin
                            gain_next = svae_pkg::UNITY_GAIN;
                            mode_next = sustain_reg ? svae_pkg::MODE_PLAYING
                                                    : svae_pkg::MODE_DECAY;
                        end
                        else
                            gain_next = attack_sum[svae_pkg::ENV_W-1:0];
                    end
                    svae_pkg::MODE_PLAYING:
                    begin
                        // Gain sits at unity here, so the scaled value is the raw one.
                        sample_next = tick_sample;
                        advance     = 1'b1;
                    end
                    svae_pkg::MODE_DECAY:
                    begin
                        if (decay_reg > gain_reg)
                        begin
                            gain_next  = '0;
                            mode_next  = svae_pkg::MODE_IDLE;
                            ended_next = 1'b1;
                        end
                        else
                        begin
                            sample_next = tick_sample;
                            gain_next   = gain_reg - decay_reg;
                            advance     = 1'b1;
                        end
                    end
                endcase
                if (advance)
                    phase_acc_next = phase_acc_reg + phase_step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= svae_pkg::MODE_IDLE;
            held_note_reg  <= '0;
            held_chan_reg  <= '0;
            held_key_reg   <= '0;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            gain_reg       <= '0;
        end
        else if (cmd.finish)
        begin
            mode_reg       <= mode_next;
            held_note_reg  <= held_note_next;
            held_chan_reg  <= held_chan_next;
            held_key_reg   <= held_key_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            gain_reg       <= gain_next;
        end
    end

    // Result register: holds the beat while the receiver stalls.
    logic [svae_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          matched_reg;
    logic                          busy_reg;
    logic                          ended_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            sample_reg  <= sample_next;
            matched_reg <= matched_next;
            busy_reg    <= (mode_next != svae_pkg::MODE_IDLE);
            ended_reg   <= ended_next;
        end
    end

    assign sample_out = sample_reg;
    assign matched    = matched_reg;
    assign busy_res   = busy_reg;
    assign just_ended = ended_reg;

endmodule

FILE: sv/sine_voice_with_ar_envelope_core.sv
// ----------------------------------------------------------------------------
// sine_voice_with_ar_envelope_core
// One synthesiser voice: sine oscillator with a linear attack/decay envelope.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_stall) takes one request per beat: a sample
// tick, note-on, note-off or choke. Every request yields exactly one result
// beat on the output channel (out_valid / out_stall): the sample, the match
// flag, the busy flag and the end-of-decay flag.
// A tick goes through the table read and the gain multiply, then the result
// register. Off and choke go straight to the result step. A note-on runs
// the one-bit-per-cycle restoring divider and its done check, followed by
// the exp2 table read, the two partial-product multiplies, the octave shift
// and the result step.
// One request is worked on at a time; in_stall is high from acceptance until
// the result is written to the output register. The next request may be
// accepted while that result still waits to be taken.
// While out_stall is high the result beat holds, and a finished request
// waits in its last step until the output register is free.
// Reset puts the voice in idle with zero phase and gain and loads the
// default configuration. Configuration is written through cfg_we; the user
// must write it only while the voice is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module sine_voice_with_ar_envelope_core #(
    parameter int SINE_TABLE_DEPTH = svae_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int EXP_TABLE_DEPTH  = svae_pkg::EXP_TABLE_DEPTH_DEF,
    parameter int REFERENCE_KEY    = svae_pkg::REFERENCE_KEY_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [svae_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svae_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           req_type,
    input  logic signed [15:0]                   note_ident,
    input  logic signed [15:0]                   chan,
    input  logic signed [7:0]                    key_number,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [svae_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 matched,
    output logic                                 busy_res,
    output logic                                 just_ended
);

    svae_pkg::dp_cmd_t    cmd;
    svae_pkg::dp_status_t status;

    svae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    svae_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
        .REFERENCE_KEY    (REFERENCE_KEY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .note_ident (note_ident),
        .chan       (chan),
        .key_number (key_number),
        .sample_out (sample_out),
        .matched    (matched),
        .busy_res   (busy_res),
        .just_ended (just_ended)
    );

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("voice accepted a second request while busy");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && just_ended |-> !busy_res && (sample_out == '0))
        else $error("ended voice still busy or sounding");

    a_match_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> (sample_out == '0) && !just_ended)
        else $error("matched event carried a sample");

    a_sound_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sample_out != '0) |-> busy_res)
        else $error("sample emitted by an idle voice");
`endif

endmodule
